// ----- hw/rtl/bttt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bttt_pkg
// Shared types and codes for the binary tag tree tokenizer.
// ----------------------------------------------------------------------------
package bttt_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_ROOT_TYPE  = 4'd0,
    PH_NAME_LEN   = 4'd1,
    PH_NAME       = 4'd2,
    PH_LIST_TYPE  = 4'd3,
    PH_LIST_COUNT = 4'd4,
    PH_ARR_LEN    = 4'd5,
    PH_SCALAR     = 4'd6,
    PH_CONTENT    = 4'd7,
    PH_INT_ELEM   = 4'd8,
    PH_ENTRY_TYPE = 4'd9,
    PH_DONE       = 4'd10,
    PH_ERROR      = 4'd11
  } phase_t;

  // Byte roles reported per item
  localparam logic [3:0] ROLE_ENTRY_TYPE = 4'd0;
  localparam logic [3:0] ROLE_NAME_LEN   = 4'd1;
  localparam logic [3:0] ROLE_NAME       = 4'd2;
  localparam logic [3:0] ROLE_LIST_TYPE  = 4'd3;
  localparam logic [3:0] ROLE_LIST_COUNT = 4'd4;
  localparam logic [3:0] ROLE_ARR_LEN    = 4'd5;
  localparam logic [3:0] ROLE_SCALAR     = 4'd6;
  localparam logic [3:0] ROLE_CONTENT    = 4'd7;
  localparam logic [3:0] ROLE_END        = 4'd8;
  localparam logic [3:0] ROLE_IGNORED    = 4'd9;

  // Tag types
  localparam logic [3:0] TAG_END        = 4'd0;
  localparam logic [3:0] TAG_BYTE       = 4'd1;
  localparam logic [3:0] TAG_SHORT      = 4'd2;
  localparam logic [3:0] TAG_INT        = 4'd3;
  localparam logic [3:0] TAG_LONG       = 4'd4;
  localparam logic [3:0] TAG_FLOAT      = 4'd5;
  localparam logic [3:0] TAG_DOUBLE     = 4'd6;
  localparam logic [3:0] TAG_BYTE_ARRAY = 4'd7;
  localparam logic [3:0] TAG_STRING     = 4'd8;
  localparam logic [3:0] TAG_LIST       = 4'd9;
  localparam logic [3:0] TAG_COMPOUND   = 4'd10;
  localparam logic [3:0] TAG_INT_ARRAY  = 4'd11;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
  localparam logic [1:0] ERR_END_LIST  = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

  // Field byte counts
  localparam logic [31:0] LEN_8B = 32'd8;
  localparam logic [31:0] LEN_4B = 32'd4;
  localparam logic [31:0] LEN_2B = 32'd2;
  localparam logic [31:0] LEN_1B = 32'd1;

  // Register index
  localparam logic REG_DEPTH_LIMIT = 1'b0;

  // Frame store write requests
  typedef struct packed {
    logic        elem_we;
    logic [3:0]  elem_val;
    logic        cnt_we;
    logic [31:0] cnt_val;
    logic        push_we;
    logic        push_is_list;
  } stack_wr_t;

  // Frame found by the unwind search
  typedef struct packed {
    logic        found;
    logic        is_list;
    logic [3:0]  elem;
    logic [31:0] count;
  } stack_rd_t;

  // One result item
  typedef struct packed {
    logic [3:0]  role;
    logic [3:0]  item_type;
    logic [4:0]  nest_depth;
    logic [63:0] value;
    logic        value_done;
    logic        doc_done;
    logic [1:0]  error_code;
  } token_t;

endpackage

// ----- hw/rtl/bttt_frame_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bttt_frame_stack
// Frame store for open compounds and lists, with the unwind search that
// finds the deepest frame still expecting content.
// ----------------------------------------------------------------------------
module bttt_frame_stack import bttt_pkg::*; #(
  parameter int MAX_DEPTH = 16,
  parameter int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  parameter int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            we,
  input  stack_wr_t       wr,
  input  logic [AW-1:0]   elem_idx,
  input  logic [AW-1:0]   cnt_idx,
  input  logic [AW-1:0]   push_idx,
  input  logic [DW-1:0]   search_depth,
  input  logic            ovr_en,
  input  logic [31:0]     ovr_count,
  output logic [AW-1:0]   found_idx,
  output stack_rd_t       rd
);

  logic              is_list [MAX_DEPTH];
  logic [3:0]        elem    [MAX_DEPTH];
  logic [31:0]       count   [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] spent;
  logic [MAX_DEPTH-1:0] spent_eff;
  logic [DW-1:0]     top_pos;
  logic              hit;
  logic [AW-1:0]     idx;
  logic              at_top;

  // Write frames
  always_ff @(posedge clk) begin
    if (we && wr.elem_we) begin
      elem[elem_idx] <= wr.elem_val;
    end
    if (we && wr.cnt_we) begin
      count[cnt_idx] <= wr.cnt_val;
      spent[cnt_idx] <= (wr.cnt_val == 32'd0);
    end
    if (we && wr.push_we) begin
      is_list[push_idx] <= wr.push_is_list;
      elem[push_idx]    <= TAG_END;
      count[push_idx]   <= 32'd0;
      spent[push_idx]   <= wr.push_is_list;
    end
  end

  // Overlay a list count written in this cycle
  assign top_pos = search_depth - DW'(1);
  always_comb begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (ovr_en && (DW'(i) == top_pos)) begin
        spent_eff[i] = (ovr_count == 32'd0);
      end else begin
        spent_eff[i] = spent[i];
      end
    end
  end

  // Find the deepest open frame below the search depth that is not spent
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((DW'(i) < search_depth) && !spent_eff[i]) begin
        hit = 1'b1;
        idx = AW'(i);
      end
    end
  end

  assign at_top     = ovr_en && ({{(DW-AW){1'b0}}, idx} == top_pos);
  assign found_idx  = idx;
  assign rd.found   = hit;
  assign rd.is_list = is_list[idx];
  assign rd.elem    = elem[idx];
  assign rd.count   = at_top ? ovr_count : count[idx];

endmodule

// ----- hw/rtl/bttt_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bttt_parser
// Parse state registers and the per-byte next-state and token logic.
// ----------------------------------------------------------------------------
module bttt_parser import bttt_pkg::*; #(
  parameter int MAX_DEPTH = 16,
  parameter int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  parameter int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      data_byte,
  input  logic            doc_start,
  input  logic [4:0]      depth_limit,
  // frame store
  output stack_wr_t       wr,
  output logic [AW-1:0]   elem_idx,
  output logic [AW-1:0]   cnt_idx,
  output logic [AW-1:0]   push_idx,
  output logic [DW-1:0]   search_depth,
  output logic            ovr_en,
  output logic [31:0]     ovr_count,
  input  logic [AW-1:0]   found_idx,
  input  stack_rd_t       rd,
  output token_t          tok
);

  localparam logic [7:0] MAX8 = 8'(MAX_DEPTH);

  phase_t       phase, phase_next, ph0;
  logic [DW-1:0] depth, depth_next, dp0;
  logic [31:0]  bytes_left, bytes_left_next, bl0;
  logic [31:0]  items_left, items_left_next, il0;
  logic [63:0]  assembly, assembly_next, as0;
  logic [3:0]   cur_type, cur_type_next, ct0;
  logic [1:0]   err, err_next, er0;
  logic [7:0]   lim8;
  logic [31:0]  il_shift;
  logic [63:0]  as_shift;
  logic [31:0]  bl_dec;

  // Clear-adjusted current state
  always_comb begin
    if (doc_start) begin
      ph0 = PH_ROOT_TYPE; dp0 = '0; bl0 = '0; il0 = '0;
      as0 = '0; ct0 = TAG_END; er0 = ERR_NONE;
    end else begin
      ph0 = phase; dp0 = depth; bl0 = bytes_left; il0 = items_left;
      as0 = assembly; ct0 = cur_type; er0 = err;
    end
  end

  assign lim8     = ({3'd0, depth_limit} > MAX8) ? MAX8 : {3'd0, depth_limit};
  assign il_shift = {il0[23:0], data_byte};
  assign as_shift = {as0[55:0], data_byte};
  assign bl_dec   = bl0 - 32'd1;

  // Unwind search set-up
  assign search_depth = ((ph0 == PH_ENTRY_TYPE) && (dp0 != '0)) ? dp0 - DW'(1) : dp0;
  assign ovr_en       = (ph0 == PH_LIST_COUNT);
  assign ovr_count    = il_shift;
  assign elem_idx     = AW'(dp0 - DW'(1));
  assign cnt_idx      = found_idx;

  logic          do_ve, se_go, ignored;
  logic [3:0]    se_t;
  logic [DW-1:0] base;

  always_comb begin
    phase_next = ph0; depth_next = dp0; bytes_left_next = bl0;
    items_left_next = il0; assembly_next = as0; cur_type_next = ct0;
    err_next = er0;
    tok = '0;
    tok.role = ROLE_IGNORED;
    wr = '0;
    push_idx = '0;
    do_ve = 1'b0; se_go = 1'b0; se_t = TAG_END; ignored = 1'b0;
    base = dp0;

    case (ph0)
      PH_ROOT_TYPE, PH_ENTRY_TYPE: begin
        if ((ph0 == PH_ENTRY_TYPE) && (data_byte == 8'd0)) begin
          tok.role = ROLE_END;
          cur_type_next = TAG_END;
          do_ve = 1'b1;
        end else begin
          tok.role = ROLE_ENTRY_TYPE;
          if ((data_byte == 8'd0) || (data_byte > 8'(TAG_INT_ARRAY))) begin
            cur_type_next = TAG_END;
            err_next = ERR_UNKNOWN;
            phase_next = PH_ERROR;
          end else begin
            cur_type_next = data_byte[3:0];
            bytes_left_next = LEN_2B;
            items_left_next = '0;
            phase_next = PH_NAME_LEN;
          end
        end
      end
      PH_NAME_LEN: begin
        tok.role = ROLE_NAME_LEN;
        items_left_next = il_shift;
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          if (il_shift == '0) begin
            se_go = 1'b1; se_t = ct0;
          end else begin
            bytes_left_next = il_shift;
            phase_next = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        tok.role = ROLE_NAME;
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          se_go = 1'b1; se_t = ct0;
        end
      end
      PH_LIST_TYPE: begin
        tok.role = ROLE_LIST_TYPE;
        if (data_byte == 8'd0) begin
          err_next = ERR_END_LIST;
          phase_next = PH_ERROR;
        end else if (data_byte > 8'(TAG_INT_ARRAY)) begin
          err_next = ERR_UNKNOWN;
          phase_next = PH_ERROR;
        end else begin
          wr.elem_we = 1'b1;
          wr.elem_val = data_byte[3:0];
          bytes_left_next = LEN_4B;
          items_left_next = '0;
          phase_next = PH_LIST_COUNT;
        end
      end
      PH_LIST_COUNT: begin
        tok.role = ROLE_LIST_COUNT;
        items_left_next = il_shift;
        bytes_left_next = bl_dec;
        if (bl_dec == '0) do_ve = 1'b1;
      end
      PH_ARR_LEN: begin
        tok.role = ROLE_ARR_LEN;
        items_left_next = il_shift;
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          if (il_shift == '0) begin
            do_ve = 1'b1;
          end else if (ct0 == TAG_INT_ARRAY) begin
            bytes_left_next = LEN_4B;
            assembly_next = '0;
            phase_next = PH_INT_ELEM;
          end else begin
            bytes_left_next = il_shift;
            phase_next = PH_CONTENT;
          end
        end
      end
      PH_SCALAR: begin
        tok.role = ROLE_SCALAR;
        assembly_next = as_shift;
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          case (ct0)
            TAG_BYTE:  tok.value = {{56{as_shift[7]}}, as_shift[7:0]};
            TAG_SHORT: tok.value = {{48{as_shift[15]}}, as_shift[15:0]};
            TAG_INT:   tok.value = {{32{as_shift[31]}}, as_shift[31:0]};
            TAG_FLOAT: tok.value = {32'd0, as_shift[31:0]};
            default:   tok.value = as_shift;
          endcase
          tok.value_done = 1'b1;
          do_ve = 1'b1;
        end
      end
      PH_CONTENT: begin
        tok.role = ROLE_CONTENT;
        bytes_left_next = bl_dec;
        if (bl_dec == '0) do_ve = 1'b1;
      end
      PH_INT_ELEM: begin
        tok.role = ROLE_CONTENT;
        assembly_next = as_shift;
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          tok.value = {{32{as_shift[31]}}, as_shift[31:0]};
          tok.value_done = 1'b1;
          items_left_next = il0 - 32'd1;
          if (il0 == 32'd1) begin
            do_ve = 1'b1;
          end else begin
            bytes_left_next = LEN_4B;
            assembly_next = '0;
          end
        end
      end
      default: begin
        ignored = 1'b1;
      end
    endcase

    // Close finished frames and advance in the enclosing one
    if (do_ve) begin
      if (!rd.found) begin
        depth_next = '0;
        phase_next = PH_DONE;
        tok.doc_done = 1'b1;
      end else begin
        depth_next = DW'(found_idx) + DW'(1);
        if (!rd.is_list) begin
          phase_next = PH_ENTRY_TYPE;
        end else begin
          wr.cnt_we = 1'b1;
          wr.cnt_val = rd.count - 32'd1;
          se_go = 1'b1;
          se_t = rd.elem;
        end
      end
    end
    base = depth_next;

    // Start reading a payload of type se_t
    if (se_go) begin
      cur_type_next = se_t;
      case (se_t)
        TAG_BYTE, TAG_SHORT, TAG_INT, TAG_LONG, TAG_FLOAT, TAG_DOUBLE: begin
          if (se_t == TAG_BYTE) bytes_left_next = LEN_1B;
          else if (se_t == TAG_SHORT) bytes_left_next = LEN_2B;
          else if ((se_t == TAG_LONG) || (se_t == TAG_DOUBLE)) bytes_left_next = LEN_8B;
          else bytes_left_next = LEN_4B;
          assembly_next = '0;
          phase_next = PH_SCALAR;
        end
        TAG_BYTE_ARRAY, TAG_INT_ARRAY, TAG_STRING: begin
          bytes_left_next = (se_t == TAG_STRING) ? LEN_2B : LEN_4B;
          items_left_next = '0;
          phase_next = PH_ARR_LEN;
        end
        TAG_LIST, TAG_COMPOUND: begin
          if (8'(base) >= lim8) begin
            err_next = ERR_OVERFLOW;
            phase_next = PH_ERROR;
          end else begin
            wr.push_we = 1'b1;
            wr.push_is_list = (se_t == TAG_LIST);
            push_idx = AW'(base);
            depth_next = base + DW'(1);
            phase_next = (se_t == TAG_LIST) ? PH_LIST_TYPE : PH_ENTRY_TYPE;
          end
        end
        default: begin
          cur_type_next = TAG_END;
          err_next = ERR_UNKNOWN;
          phase_next = PH_ERROR;
        end
      endcase
    end

    tok.item_type  = ignored ? 4'd0 : cur_type_next;
    tok.nest_depth = ignored ? 5'd0 : 5'(depth_next);
    tok.error_code = err_next;
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ROOT_TYPE;
      depth <= '0;
      bytes_left <= '0;
      items_left <= '0;
      assembly <= '0;
      cur_type <= TAG_END;
      err <= ERR_NONE;
    end else if (fire) begin
      phase <= phase_next;
      depth <= depth_next;
      bytes_left <= bytes_left_next;
      items_left <= items_left_next;
      assembly <= assembly_next;
      cur_type <= cur_type_next;
      err <= err_next;
    end
  end

endmodule

// ----- hw/rtl/binary_tag_tree_tokenizer_top.sv -----
`timescale 1ns / 1ps
// Output: a token appears on the master side in the cycle after its byte is taken.
// Throughput: one byte per cycle while the token register is free or being read;
// parse state and frame store update in the cycle the byte is taken; the token register frees itself when read.
// Reset: synchronous, active high; clears parse state, the token valid flag and
// sets depth_limit to 16. The frame store needs no clearing.
// ----------------------------------------------------------------------------
// binary_tag_tree_tokenizer_top
// Streaming tokenizer for big-endian named binary tag documents.
// ----------------------------------------------------------------------------
module binary_tag_tree_tokenizer_top import bttt_pkg::*; #(
  parameter int MAX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] doc_start
  // token output
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] role, [7:4] item_type, [12:8] nest_depth, [76:13] value,
  // [77] value_done, [79:78] error_code
  output logic [79:0] m_tdata,
  output logic        m_tlast,   // doc_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic [4:0]    depth_limit;
  logic          fire;
  stack_wr_t     wr;
  stack_rd_t     rd;
  logic [AW-1:0] elem_idx, cnt_idx, push_idx, found_idx;
  logic [DW-1:0] search_depth;
  logic          ovr_en;
  logic [31:0]   ovr_count;
  token_t        tok;
  token_t        out_tok;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= 5'd16;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DEPTH_LIMIT)) begin
      depth_limit <= pwdata[4:0];
    end
  end
  assign prdata = (paddr[2] == REG_DEPTH_LIMIT) ? {27'd0, depth_limit} : 32'd0;

  // Take a byte whenever the token register is free or being read
  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;

  bttt_parser #(.MAX_DEPTH(MAX_DEPTH), .AW(AW), .DW(DW)) u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .data_byte    (s_tdata),
    .doc_start    (s_tuser),
    .depth_limit  (depth_limit),
    .wr           (wr),
    .elem_idx     (elem_idx),
    .cnt_idx      (cnt_idx),
    .push_idx     (push_idx),
    .search_depth (search_depth),
    .ovr_en       (ovr_en),
    .ovr_count    (ovr_count),
    .found_idx    (found_idx),
    .rd           (rd),
    .tok          (tok)
  );

  bttt_frame_stack #(.MAX_DEPTH(MAX_DEPTH), .AW(AW), .DW(DW)) u_stack (
    .clk          (clk),
    .we           (fire),
    .wr           (wr),
    .elem_idx     (elem_idx),
    .cnt_idx      (cnt_idx),
    .push_idx     (push_idx),
    .search_depth (search_depth),
    .ovr_en       (ovr_en),
    .ovr_count    (ovr_count),
    .found_idx    (found_idx),
    .rd           (rd)
  );

  // Hold the token until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tok <= tok;
    end
  end

  assign m_tdata = {out_tok.error_code, out_tok.value_done, out_tok.value,
                    out_tok.nest_depth, out_tok.item_type, out_tok.role};
  assign m_tlast = out_tok.doc_done;

`ifndef NO_ASSERTIONS
  a_fire_gives_token: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid) else $error("token lost after byte taken");
  a_value_role: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[77]) |-> (m_tdata[3:0] == ROLE_SCALAR ||
                                   m_tdata[3:0] == ROLE_CONTENT))
    else $error("value completed on a non-value byte");
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[12:8] == 5'd0 && m_tdata[79:78] == ERR_NONE))
    else $error("document closed with open frames or error");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({27'd0, m_tdata[12:8]} <= 32'(MAX_DEPTH)))
    else $error("nesting depth beyond frame store");
`endif

endmodule
